// ===== sv/mhpq_pkg.sv =====
// Shared constants, types and state codes for the min-heap priority queue.
package mhpq_pkg;

	localparam int HEAP_DEPTH = 16;
	localparam int PRI_W      = 16;
	localparam int DATA_W     = 32;
	localparam int CFG_W      = 5;
	localparam int OUT_CNT_W  = 5;

	// Positions run from 1 to HEAP_DEPTH; the fill count shares that width.
	localparam int POS_W  = $clog2(HEAP_DEPTH + 1);
	localparam int ADDR_W = $clog2(HEAP_DEPTH);
	localparam int CAP_W  = (POS_W > CFG_W) ? POS_W : CFG_W;
	localparam int EXT_W  = (POS_W > OUT_CNT_W) ? POS_W : OUT_CNT_W;

	localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(16);

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	typedef struct packed {
		logic [PRI_W-1:0]  pri;
		logic [DATA_W-1:0] dat;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DEL_RD,
		ST_DEL_LAT,
		ST_DN_RD,
		ST_DN_CMP,
		ST_FIN
	} state_t;

endpackage

// ===== sv/min_heap_priority_queue_top.sv =====
// Binary min-heap priority queue held in a synchronous single-write, dual-read memory.
//
// Usage: a request enters on the in_valid/in_ready channel. req_type selects an
// insert of (item_priority, item_data) or a delete of the minimum entry. Every
// request yields exactly one result on the out_valid/out_ready channel: success,
// removed_data (payload of the removed root on a good delete, else zero) and
// entry_count, the number of entries held afterwards.
// The queue handles one request at a time. An insert climbs the new entry from the
// first free slot towards the root; a delete moves the last entry to the root and
// sinks it, unless the delete empties the heap; a refused request (insert into a full
// heap, delete from an empty one) goes straight to the final step. The queue returns
// to idle before the next request is taken. Each sift level needs one memory read,
// a compare and one write-back.
// The result sits in an output register; the next request is taken while that
// result still waits, and only the final step of the following request waits
// when the receiver stalls. The user must write capacity_limit through
// cfg_we/cfg_wdata only while the queue is idle; the block does not enforce this.
// The effective capacity is the smaller of it and the memory depth. Reset (arst_n
// low) empties the heap and sets the capacity to 16.
module min_heap_priority_queue_top
	import mhpq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [PRI_W-1:0]  item_priority,
	input  logic [DATA_W-1:0] item_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              success,
	output logic [DATA_W-1:0] removed_data,
	output logic [OUT_CNT_W-1:0] entry_count
);

	// Entry memory: slot p of the heap lives at address p-1.
	entry_t mem [HEAP_DEPTH];

	state_t state_q, state_d;

	logic [CFG_W-1:0]  capacity_q;
	logic [POS_W-1:0]  count_q;
	logic [POS_W-1:0]  pos_q;
	entry_t            move_q;       // entry being sifted
	logic              ok_q;
	logic [DATA_W-1:0] removed_q;

	logic              out_valid_q;
	logic              success_q;
	logic [DATA_W-1:0] removed_data_q;
	logic [OUT_CNT_W-1:0] entry_count_q;

	// Memory port controls.
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	entry_t            mem_wdata;
	logic [ADDR_W-1:0] mem_raddr_a, mem_raddr_b;
	entry_t            rd_a, rd_b;

	logic              accept;
	logic [CAP_W-1:0]  eff_cap;
	logic              heap_full;
	logic [POS_W-1:0]  parent_pos;
	logic [POS_W:0]    left_pos;
	logic [POS_W:0]    right_pos;
	logic [POS_W:0]    count_ext;
	logic              left_beyond;
	logic              right_valid;
	logic              take_right;
	entry_t            pick_entry;
	logic              out_free;
	logic [EXT_W-1:0]  count_out_ext;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign eff_cap   = (CAP_W'(capacity_q) < CAP_W'(HEAP_DEPTH)) ?
		CAP_W'(capacity_q) : CAP_W'(HEAP_DEPTH);
	assign heap_full = CAP_W'(count_q) >= eff_cap;

	assign parent_pos  = pos_q >> 1;
	assign left_pos    = {pos_q, 1'b0};
	assign right_pos   = left_pos + (POS_W+1)'(1);
	assign count_ext   = (POS_W+1)'(count_q);
	assign left_beyond = left_pos > count_ext;
	assign right_valid = right_pos <= count_ext;
	// On a tie the left child wins.
	assign take_right  = right_valid && (rd_b.pri < rd_a.pri);
	assign pick_entry  = take_right ? rd_b : rd_a;

	assign count_out_ext = EXT_W'(count_q);

	// Memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_a <= mem[mem_raddr_a];
		rd_b <= mem[mem_raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory accesses.
	always_comb begin
		state_d     = state_q;
		mem_we      = 1'b0;
		mem_waddr   = ADDR_W'(pos_q - POS_W'(1));
		mem_wdata   = move_q;
		mem_raddr_a = ADDR_W'(left_pos - (POS_W+1)'(1));
		mem_raddr_b = ADDR_W'(left_pos);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_INSERT) begin
						state_d = heap_full ? ST_FIN : ST_UP_RD;
					end else begin
						state_d = (count_q == '0) ? ST_FIN : ST_DEL_RD;
					end
				end
			end
			ST_UP_RD: begin
				if (pos_q == POS_W'(1)) begin
					mem_we  = 1'b1;
					state_d = ST_FIN;
				end else begin
					mem_raddr_a = ADDR_W'(parent_pos - POS_W'(1));
					state_d     = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				mem_we = 1'b1;
				if (move_q.pri < rd_a.pri) begin
					mem_wdata = rd_a;
					state_d   = ST_UP_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DEL_RD: begin
				mem_raddr_a = '0;
				mem_raddr_b = ADDR_W'(count_q - POS_W'(1));
				state_d     = ST_DEL_LAT;
			end
			ST_DEL_LAT: begin
				state_d = (count_q == POS_W'(1)) ? ST_FIN : ST_DN_RD;
			end
			ST_DN_RD: begin
				if (left_beyond) begin
					mem_we  = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				mem_we = 1'b1;
				if (move_q.pri <= pick_entry.pri) begin
					state_d = ST_FIN;
				end else begin
					mem_wdata = pick_entry;
					state_d   = ST_DN_RD;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: capacity and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			count_q    <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			case (state_q)
				ST_UP_RD: begin
					if (pos_q == POS_W'(1)) begin
						count_q <= count_q + POS_W'(1);
					end
				end
				ST_UP_CMP: begin
					if (!(move_q.pri < rd_a.pri)) begin
						count_q <= count_q + POS_W'(1);
					end
				end
				ST_DEL_LAT: begin
					count_q <= count_q - POS_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the request in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ok_q       <= 1'b0;
					removed_q  <= '0;
					pos_q      <= count_q + POS_W'(1);
					move_q.pri <= item_priority;
					move_q.dat <= item_data;
				end
			end
			ST_UP_RD: begin
				if (pos_q == POS_W'(1)) begin
					ok_q <= 1'b1;
				end
			end
			ST_UP_CMP: begin
				if (move_q.pri < rd_a.pri) begin
					pos_q <= parent_pos;
				end else begin
					ok_q <= 1'b1;
				end
			end
			ST_DEL_LAT: begin
				// The root leaves, the last entry starts its sift at the root.
				ok_q      <= 1'b1;
				removed_q <= rd_a.dat;
				move_q    <= rd_b;
				pos_q     <= POS_W'(1);
			end
			ST_DN_CMP: begin
				pos_q <= take_right ? POS_W'(right_pos) : POS_W'(left_pos);
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			success_q      <= ok_q;
			removed_data_q <= removed_q;
			entry_count_q  <= count_out_ext[OUT_CNT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign success      = success_q;
	assign removed_data = removed_data_q;
	assign entry_count  = entry_count_q;

endmodule

// ===== tb/min_heap_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the min-heap priority queue, checked against its own heap model.
module min_heap_priority_queue_top_tb;
	import mhpq_pkg::*;

	// One result as the queue reports it.
	typedef struct packed {
		logic                 ok;
		logic [DATA_W-1:0]    removed;
		logic [OUT_CNT_W-1:0] count;
	} heap_result_t;

	// A directed row is either a request or a write of the capacity register.
	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic              rq;
		logic [PRI_W-1:0]  pri;
		logic [DATA_W-1:0] dat;
		logic              typed;
		heap_result_t      want;
	} stim_row_t;

	localparam logic TYPED = 1'b1;
	localparam logic PRED  = 1'b0;

	// Directed part. Rows marked TYPED carry a result that can be read off at a glance;
	// the others are checked against the heap model. A capacity row holds the new
	// register value in its data column.
	localparam int DIR_N = 26;
	localparam stim_row_t DIR_ROWS [DIR_N] = '{
		// Delete from an empty heap after reset is refused.
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, TYPED, '{1'b0, 32'h0, 5'd0}},
		// Extreme priorities and payloads.
		'{ROW_REQ, REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF, TYPED, '{1'b1, 32'h0, 5'd1}},
		'{ROW_REQ, REQ_INSERT, 16'h0000, 32'h0000_0000, TYPED, '{1'b1, 32'h0, 5'd2}},
		// Three equal priorities so that sift-down has to break ties.
		'{ROW_REQ, REQ_INSERT, 16'h8000, 32'hA5A5_A5A5, PRED, '0},
		'{ROW_REQ, REQ_INSERT, 16'h8000, 32'h5A5A_5A5A, PRED, '0},
		'{ROW_REQ, REQ_INSERT, 16'h7FFF, 32'h1234_5678, PRED, '0},
		'{ROW_REQ, REQ_INSERT, 16'h8000, 32'h0F0F_0F0F, PRED, '0},
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, TYPED, '{1'b1, 32'h0, 5'd5}},
		'{ROW_REQ, REQ_DELETE, 16'hFFFF, 32'hFFFF_FFFF, PRED, '0},
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, PRED, '0},
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, PRED, '0},
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, PRED, '0},
		// Deleting the last entry empties the heap without a sift.
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, TYPED,
			'{1'b1, 32'hFFFF_FFFF, 5'd0}},
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, TYPED, '{1'b0, 32'h0, 5'd0}},
		// A capacity of one: the second insert finds the heap full.
		'{ROW_CFG, REQ_INSERT, 16'h0000, 32'd1, PRED, '0},
		'{ROW_REQ, REQ_INSERT, 16'h1234, 32'hDEAD_BEEF, TYPED, '{1'b1, 32'h0, 5'd1}},
		'{ROW_REQ, REQ_INSERT, 16'h0000, 32'hCAFE_F00D, TYPED, '{1'b0, 32'h0, 5'd1}},
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, TYPED,
			'{1'b1, 32'hDEAD_BEEF, 5'd0}},
		// A capacity of zero refuses every insert.
		'{ROW_CFG, REQ_INSERT, 16'h0000, 32'd0, PRED, '0},
		'{ROW_REQ, REQ_INSERT, 16'h0000, 32'h0000_0001, TYPED, '{1'b0, 32'h0, 5'd0}},
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, TYPED, '{1'b0, 32'h0, 5'd0}},
		// A capacity beyond the depth is clipped to the depth.
		'{ROW_CFG, REQ_INSERT, 16'h0000, 32'd31, PRED, '0},
		'{ROW_REQ, REQ_INSERT, 16'hFFFF, 32'h8000_0000, PRED, '0},
		'{ROW_REQ, REQ_INSERT, 16'h0001, 32'h7FFF_FFFF, PRED, '0},
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, PRED, '0},
		'{ROW_REQ, REQ_DELETE, 16'h0000, 32'h0000_0000, TYPED,
			'{1'b1, 32'h8000_0000, 5'd0}}
	};

	// Random phases, each with its own capacity, length and idling rate. The phase
	// that draws a random capacity is marked by RAND_CAP_PHASE. The last phase runs
	// with no idling on either side.
	localparam int PHASE_N        = 8;
	localparam int RAND_CAP_PHASE = 5;
	localparam int PHASE_CAP  [PHASE_N] = '{16, 31, 4, 1, 0, 0, 2, 16};
	localparam int PHASE_LEN  [PHASE_N] = '{80, 70, 50, 25, 15, 60, 40, 60};
	localparam int PHASE_IDLE [PHASE_N] = '{4, 3, 0, 6, 4, 5, 2, 0};

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [CFG_W-1:0]     cfg_wdata     = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic                 req_type      = REQ_INSERT;
	logic [PRI_W-1:0]     item_priority = '0;
	logic [DATA_W-1:0]    item_data     = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic                 success;
	logic [DATA_W-1:0]    removed_data;
	logic [OUT_CNT_W-1:0] entry_count;

	// Heap model: slots 1..heap_fill are occupied, root at slot 1.
	logic [PRI_W-1:0]  heap_pri [1:HEAP_DEPTH];
	logic [DATA_W-1:0] heap_dat [1:HEAP_DEPTH];
	int                heap_fill = 0;
	logic [CFG_W-1:0]  heap_cap  = CAPACITY_RESET;

	// Results that the queue still owes, oldest first.
	heap_result_t owed_results [$];

	int mismatches = 0;
	// Chance of an idle burst is one in idle_odds; zero turns idling off.
	int idle_odds  = 4;

	min_heap_priority_queue_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.item_priority (item_priority),
		.item_data     (item_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.success       (success),
		.removed_data  (removed_data),
		.entry_count   (entry_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one request to the heap model and returns the result it should give.
	function automatic heap_result_t heap_apply(input logic rq, input logic [PRI_W-1:0] pri,
			input logic [DATA_W-1:0] dat);
		heap_result_t      r;
		int                room;
		int                pos;
		int                kid;
		logic [PRI_W-1:0]  moved_pri;
		logic [DATA_W-1:0] moved_dat;
		r = '0;
		room = (int'(heap_cap) < HEAP_DEPTH) ? int'(heap_cap) : HEAP_DEPTH;
		if (rq == REQ_INSERT) begin
			if (heap_fill < room) begin
				// Climb while strictly smaller than the parent.
				pos = heap_fill + 1;
				while (pos > 1 && pri < heap_pri[pos / 2]) begin
					heap_pri[pos] = heap_pri[pos / 2];
					heap_dat[pos] = heap_dat[pos / 2];
					pos = pos / 2;
				end
				heap_pri[pos] = pri;
				heap_dat[pos] = dat;
				heap_fill++;
				r.ok = 1'b1;
			end
		end else if (heap_fill > 0) begin
			r.ok = 1'b1;
			r.removed = heap_dat[1];
			moved_pri = heap_pri[heap_fill];
			moved_dat = heap_dat[heap_fill];
			heap_fill--;
			if (heap_fill > 0) begin
				// Sink the last entry from the root; the left child wins a tie.
				pos = 1;
				while (2 * pos <= heap_fill) begin
					kid = 2 * pos;
					if (kid + 1 <= heap_fill && heap_pri[kid + 1] < heap_pri[kid])
						kid++;
					if (moved_pri <= heap_pri[kid])
						break;
					heap_pri[pos] = heap_pri[kid];
					heap_dat[pos] = heap_dat[kid];
					pos = kid;
				end
				heap_pri[pos] = moved_pri;
				heap_dat[pos] = moved_dat;
			end
		end
		r.count = OUT_CNT_W'(heap_fill);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 50)
			$display("%0t ns: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Presents one request from a falling edge and holds it until it is accepted.
	// The owed result is taken from the table row when typed, otherwise from the model;
	// the model is advanced either way. Returns at the falling edge after acceptance,
	// with valid still high so that a following request can follow at once.
	task automatic send_request(input logic rq, input logic [PRI_W-1:0] pri,
			input logic [DATA_W-1:0] dat, input logic typed, input heap_result_t want);
		heap_result_t predicted;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= rq;
		item_priority <= pri;
		item_data     <= dat;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = heap_apply(rq, pri, dat);
		owed_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Stops sending and waits until every owed result has been taken. Since each
	// request gives exactly one result, the queue is idle after that.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Writes the capacity register; only called while the queue is idle.
	task automatic write_capacity(input logic [CFG_W-1:0] value);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
		heap_cap = value;
	endtask

	// Receiver: ready stays high except for random stall bursts.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1)
				stall_left = $urandom_range(1, 15);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Each accepted result is compared with the oldest owed one, field by field.
	always @(posedge clk) begin
		heap_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				report_mismatch("result arrived with nothing owed");
			end else begin
				want = owed_results.pop_front();
				if (success !== want.ok)
					report_mismatch($sformatf("success %b, expected %b", success, want.ok));
				if (removed_data !== want.removed)
					report_mismatch($sformatf("removed_data %h, expected %h",
						removed_data, want.removed));
				if (entry_count !== want.count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						entry_count, want.count));
			end
		end
	end

	initial begin : stimulus
		int               ph;
		int               k;
		int               cap;
		int               insert_pct;
		logic             rq;
		logic [PRI_W-1:0] pri;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < DIR_N; k++) begin
			if (DIR_ROWS[k].kind == ROW_CFG) begin
				wait_drain();
				write_capacity(DIR_ROWS[k].dat[CFG_W-1:0]);
			end else begin
				send_request(DIR_ROWS[k].rq, DIR_ROWS[k].pri, DIR_ROWS[k].dat,
					DIR_ROWS[k].typed, DIR_ROWS[k].want);
			end
		end

		for (ph = 0; ph < PHASE_N; ph++) begin
			wait_drain();
			cap = (ph == RAND_CAP_PHASE) ? $urandom_range(5, 15) : PHASE_CAP[ph];
			write_capacity(CFG_W'(cap));
			idle_odds = PHASE_IDLE[ph];
			for (k = 0; k < PHASE_LEN[ph]; k++) begin
				// Now and then the sender holds off until the queue has answered everything.
				if ($urandom_range(0, 59) == 0)
					wait_drain();
				// Alternate fill-heavy and drain-heavy stretches so that the heap
				// regularly reaches both full and empty.
				insert_pct = ((k / 24) % 2 == 0) ? 75 : 30;
				rq = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
				// Mix full-range priorities with narrow bands that force ties,
				// and with the two ends of the range.
				case ($urandom_range(0, 3))
					0: pri = PRI_W'($urandom_range(0, 65535));
					1: pri = PRI_W'($urandom_range(0, 7));
					2: pri = $urandom_range(0, 1) ? '1 : '0;
					default: pri = PRI_W'($urandom_range(65528, 65535));
				endcase
				send_request(rq, pri, $urandom, PRED, '0);
			end
		end

		wait_drain();
		repeat (16) @(negedge clk);
		if (mismatches == 0)
			$display("min_heap_priority_queue_top_tb OK");
		else
			$display("min_heap_priority_queue_top_tb NOT OK");
		$finish;
	end

	// Backstop: far longer than the slowest correct run could take.
	initial begin : watchdog
		#5000000;
		$display("min_heap_priority_queue_top_tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mhpq_pkg.sv
sv/min_heap_priority_queue_top.sv
tb/min_heap_priority_queue_top_tb.sv
